>>> hw/rtl/bts_pkg.sv
// bilinear texel sampler: shared types, codes and constants
// used by bilinear_texel_sampler_unit; no dependencies
package bts_pkg;

    localparam int TEXEL_DEPTH_DEF = 65536;
    localparam int FACE_SLOTS_DEF  = 256;

    // stream and config port widths
    localparam int S_TDATA_W = 176;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    // field widths
    localparam int DIM_W   = 13;
    localparam int CRD_W   = 14;
    localparam int MOD_W   = 14;
    localparam int POS_W   = 48;
    localparam int X_W     = 32;
    localparam int FRAC_W  = 16;
    localparam int RECT_W  = 50;
    localparam int FACE_CNT_W = 9;

    // remainder pipeline: bits of the dividend retired per stage
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = X_W / DIV_BITS;

    localparam int HALF_TEXEL = 32768;
    localparam int ONE_Q16    = 65536;
    localparam int OUT_MAX    = 65280;

    typedef enum logic [1:0] {
        MODE_WR_TEXEL = 2'd0,
        MODE_WR_RECT  = 2'd1,
        MODE_SAMPLE   = 2'd2,
        MODE_NONE     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        WRAP_CLAMP_EDGE   = 2'd0,
        WRAP_REPEAT       = 2'd1,
        WRAP_MIRROR       = 2'd2,
        WRAP_CLAMP_BORDER = 2'd3
    } wrap_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEX_WIDTH  = 3'd0,
        CFG_TEX_HEIGHT = 3'd1,
        CFG_WRAP_S     = 3'd2,
        CFG_WRAP_T     = 3'd3,
        CFG_ATLAS_MODE = 3'd4,
        CFG_FACE_COUNT = 3'd5
    } cfg_idx_t;

endpackage

>>> hw/rtl/bilinear_texel_sampler_unit.sv
// bilinear texel sampler: top level, full sampling pipeline with texel banks
// depends on bts_pkg
//
// usage:
//   s_ channel takes requests: tuser carries the mode (write texel, write face
//   rectangle, sample), tdata the remaining fields. m_ channel returns one
//   16-bit Q8.8 result per request, in request order; writes return 0.
//   cfg port writes one register per cycle; the user must write only while the
//   block is idle (not enforced by the block). throughput: one request per cycle
//   unless the output stalls. among its stages: the 8-stage remainder pipeline
//   (4 bits per stage) that wraps texel coordinates, plus the multiply, address,
//   bank read and the two blend multiplies, each in its own register stage.
// storage: four copies of the texel store, one per filter tap, each written by
//   every texel write and read at one address; the rectangle table is read when
//   a request is accepted. texel writes land at the bank stage so they stay in
//   order with samples. TEXEL_DEPTH is taken as a power of two.
// reset: clears the config registers and all valid bits; stores are undefined until
//   written. when m_tready is low with a result waiting, the whole pipeline
//   holds and s_tready drops; nothing is lost or repeated.
module bilinear_texel_sampler_unit #(
    parameter int TEXEL_DEPTH = bts_pkg::TEXEL_DEPTH_DEF,
    parameter int FACE_SLOTS  = bts_pkg::FACE_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // slot[15:0] texel_value[23:16] rect_left[35:24] rect_top[47:36]
    // rect_cols[60:48] rect_rows[73:61] coord_u[105:74] coord_v[137:106]
    // face_id[169:138], zero fill above
    input  logic [bts_pkg::S_TDATA_W-1:0] s_tdata,
    // mode[1:0]
    input  logic [bts_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // red_value[15:0]
    output logic [bts_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [bts_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [bts_pkg::CFG_DAT_W-1:0] cfg_wdata
);
    import bts_pkg::*;

    localparam int AW   = (TEXEL_DEPTH > 1) ? $clog2(TEXEL_DEPTH) : 1;
    localparam int FA_W = (FACE_SLOTS > 1) ? $clog2(FACE_SLOTS) : 1;
    localparam int SUM_W = 32;

    typedef struct packed {
        logic                    zero;
        logic                    atlas;
        logic                    is_wr;
        logic [15:0]             slot;
        logic [7:0]              wr_val;
        logic signed [POS_W-1:0] fx;
        logic signed [POS_W-1:0] fy;
        logic [CRD_W-1:0]        minx;
        logic [CRD_W-1:0]        maxx;
        logic [CRD_W-1:0]        miny;
        logic [CRD_W-1:0]        maxy;
    } pos_t;

    typedef struct packed {
        logic                    zero;
        logic                    atlas;
        logic                    is_wr;
        logic [15:0]             slot;
        logic [7:0]              wr_val;
        logic signed [X_W-1:0]   x0;
        logic signed [X_W-1:0]   y0;
        logic [FRAC_W-1:0]       tx;
        logic [FRAC_W-1:0]       ty;
        logic [CRD_W-1:0]        minx;
        logic [CRD_W-1:0]        maxx;
        logic [CRD_W-1:0]        miny;
        logic [CRD_W-1:0]        maxy;
        logic [X_W-1:0]          xnum;
        logic [X_W-1:0]          ynum;
        logic [MOD_W-1:0]        xrem;
        logic [MOD_W-1:0]        yrem;
    } div_t;

    typedef struct packed {
        logic                    zero;
        logic                    is_wr;
        logic [15:0]             slot;
        logic [7:0]              wr_val;
        logic [FRAC_W-1:0]       tx;
        logic [FRAC_W-1:0]       ty;
        logic [CRD_W-1:0]        xx0;
        logic [CRD_W-1:0]        xx1;
        logic [CRD_W-1:0]        yy0;
        logic [CRD_W-1:0]        yy1;
    } crd_t;

    typedef struct packed {
        logic                    zero;
        logic                    is_wr;
        logic [7:0]              wr_val;
        logic [FRAC_W-1:0]       tx;
        logic [FRAC_W-1:0]       ty;
        logic [3:0][AW-1:0]      addr;
    } adr_t;

    // one step of restoring remainder per dividend bit
    function automatic logic [MOD_W-1:0] rem_step(input logic [MOD_W-1:0] rem_in,
                                                  input logic [DIV_BITS-1:0] bits,
                                                  input logic [MOD_W-1:0] m);
        logic [MOD_W:0]   t;
        logic [MOD_W-1:0] rem;
        rem = rem_in;
        for (int j = DIV_BITS - 1; j >= 0; j--) begin
            t = {rem, bits[j]};
            if (t >= {1'b0, m}) begin
                t = t - {1'b0, m};
            end
            rem = t[MOD_W-1:0];
        end
        return rem;
    endfunction

    function automatic logic [CRD_W-1:0] clamp_s(input logic signed [X_W-1:0] xs,
                                                 input logic [CRD_W-1:0] lo,
                                                 input logic [CRD_W-1:0] hi);
        logic [CRD_W-1:0] res;
        if (xs < $signed({{(X_W-CRD_W){1'b0}}, lo})) begin
            res = lo;
        end else if (xs > $signed({{(X_W-CRD_W){1'b0}}, hi})) begin
            res = hi;
        end else begin
            res = xs[CRD_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [CRD_W-1:0] map_axis(input logic signed [X_W-1:0] xs,
                                                  input logic [MOD_W-1:0] r,
                                                  input logic [DIM_W-1:0] n,
                                                  input logic [MOD_W-1:0] m,
                                                  input wrap_mode_t wm,
                                                  input logic atlas,
                                                  input logic [CRD_W-1:0] lo,
                                                  input logic [CRD_W-1:0] hi);
        logic [CRD_W-1:0] res;
        logic [CRD_W-1:0] nm1;
        nm1 = CRD_W'(n) - CRD_W'(1);
        if (atlas) begin
            res = clamp_s(xs, lo, hi);
        end else if (n <= DIM_W'(1)) begin
            res = '0;
        end else begin
            unique case (wm)
                WRAP_REPEAT: res = r;
                WRAP_MIRROR: res = (r < MOD_W'(n)) ? r : m - MOD_W'(1) - r;
                WRAP_CLAMP_EDGE, WRAP_CLAMP_BORDER: res = clamp_s(xs, '0, nm1);
            endcase
        end
        return res;
    endfunction

    // configuration
    logic [DIM_W-1:0]      tex_width_reg;
    logic [DIM_W-1:0]      tex_height_reg;
    wrap_mode_t            wrap_s_reg;
    wrap_mode_t            wrap_t_reg;
    logic                  atlas_mode_reg;
    logic [FACE_CNT_W-1:0] face_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_width_reg  <= '0;
            tex_height_reg <= '0;
            wrap_s_reg     <= WRAP_CLAMP_EDGE;
            wrap_t_reg     <= WRAP_CLAMP_EDGE;
            atlas_mode_reg <= 1'b0;
            face_count_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_TEX_WIDTH:  tex_width_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_TEX_HEIGHT: tex_height_reg <= cfg_wdata[DIM_W-1:0];
                CFG_WRAP_S:     wrap_s_reg     <= wrap_mode_t'(cfg_wdata[1:0]);
                CFG_WRAP_T:     wrap_t_reg     <= wrap_mode_t'(cfg_wdata[1:0]);
                CFG_ATLAS_MODE: atlas_mode_reg <= cfg_wdata[0];
                CFG_FACE_COUNT: face_count_reg <= cfg_wdata[FACE_CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // global advance: the whole pipeline moves when the output can take a result
    logic en;
    logic s_accept;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign s_accept = s_tvalid && s_tready;

    // request fields
    mode_t              in_mode;
    logic [15:0]        in_slot;
    logic [7:0]         in_val;
    logic [11:0]        in_left;
    logic [11:0]        in_top;
    logic [12:0]        in_cols;
    logic [12:0]        in_rows;
    logic [31:0]        in_u;
    logic [31:0]        in_v;
    logic [31:0]        in_face;
    logic               in_atlas;

    assign in_mode  = mode_t'(s_tuser[1:0]);
    assign in_slot  = s_tdata[15:0];
    assign in_val   = s_tdata[23:16];
    assign in_left  = s_tdata[35:24];
    assign in_top   = s_tdata[47:36];
    assign in_cols  = s_tdata[60:48];
    assign in_rows  = s_tdata[73:61];
    assign in_u     = s_tdata[105:74];
    assign in_v     = s_tdata[137:106];
    assign in_face  = s_tdata[169:138];
    assign in_atlas = atlas_mode_reg && (in_face < {23'd0, face_count_reg})
                      && (in_face < 32'(FACE_SLOTS));

    // rectangle table, written and read at accept
    logic [RECT_W-1:0] rect_mem [FACE_SLOTS];
    logic [RECT_W-1:0] rect_rd_reg;

    always_ff @(posedge aclk) begin
        if (s_accept && in_mode == MODE_WR_RECT && {16'd0, in_slot} < 32'(FACE_SLOTS)) begin
            rect_mem[in_slot[FA_W-1:0]] <= {in_rows, in_cols, in_top, in_left};
        end
        if (en) begin
            rect_rd_reg <= rect_mem[in_face[FA_W-1:0]];
        end
    end

    // stage 1: captured request
    logic        s1_vld_reg;
    mode_t       s1_mode_reg;
    logic [15:0] s1_slot_reg;
    logic [7:0]  s1_val_reg;
    logic [31:0] s1_u_reg;
    logic [31:0] s1_v_reg;
    logic        s1_atlas_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_mode_reg  <= in_mode;
            s1_slot_reg  <= in_slot;
            s1_val_reg   <= in_val;
            s1_u_reg     <= in_u;
            s1_v_reg     <= in_v;
            s1_atlas_reg <= in_atlas;
        end
    end

    // stage 1 logic: texel-space position in Q.16
    logic [11:0]             r_left;
    logic [11:0]             r_top;
    logic [12:0]             r_cols;
    logic [12:0]             r_rows;
    logic [16:0]             cu;
    logic [16:0]             cv;
    logic [16:0]             vflip;
    logic signed [32:0]      mxa;
    logic signed [32:0]      mya;
    logic signed [14:0]      mxb;
    logic signed [14:0]      myb;
    logic signed [POS_W-1:0] offx;
    logic signed [POS_W-1:0] offy;
    pos_t                    s2_next;

    assign r_left = rect_rd_reg[11:0];
    assign r_top  = rect_rd_reg[23:12];
    assign r_cols = rect_rd_reg[36:24];
    assign r_rows = rect_rd_reg[49:37];

    always_comb begin
        if (s1_u_reg[31]) begin
            cu = '0;
        end else if ($signed(s1_u_reg) > 32'sd65536) begin
            cu = 17'(ONE_Q16);
        end else begin
            cu = s1_u_reg[16:0];
        end
        if (s1_v_reg[31]) begin
            cv = '0;
        end else if ($signed(s1_v_reg) > 32'sd65536) begin
            cv = 17'(ONE_Q16);
        end else begin
            cv = s1_v_reg[16:0];
        end
        vflip = 17'(ONE_Q16) - cv;

        if (s1_atlas_reg) begin
            mxa  = $signed({16'd0, cu});
            mya  = $signed({16'd0, vflip});
            mxb  = $signed({2'b00, r_cols - 13'd1});
            myb  = $signed({2'b00, r_rows - 13'd1});
            offx = $signed({20'd0, r_left, 16'd0});
            offy = $signed({20'd0, r_top, 16'd0});
        end else begin
            mxa  = $signed({s1_u_reg[31], s1_u_reg});
            mya  = $signed({s1_v_reg[31], s1_v_reg});
            mxb  = $signed({2'b00, tex_width_reg});
            myb  = $signed({2'b00, tex_height_reg});
            offx = -POS_W'(HALF_TEXEL);
            offy = -POS_W'(HALF_TEXEL);
        end

        s2_next.fx     = mxa * mxb + offx;
        s2_next.fy     = mya * myb + offy;
        s2_next.minx   = {2'b00, r_left};
        s2_next.miny   = {2'b00, r_top};
        s2_next.maxx   = CRD_W'({2'b00, r_left} + CRD_W'(r_cols) - CRD_W'(1));
        s2_next.maxy   = CRD_W'({2'b00, r_top} + CRD_W'(r_rows) - CRD_W'(1));
        s2_next.atlas  = s1_atlas_reg;
        s2_next.is_wr  = (s1_mode_reg == MODE_WR_TEXEL);
        s2_next.slot   = s1_slot_reg;
        s2_next.wr_val = s1_val_reg;
        s2_next.zero   = (s1_mode_reg != MODE_SAMPLE) || (tex_width_reg == '0)
                         || (tex_height_reg == '0)
                         || (s1_atlas_reg && (r_cols == '0 || r_rows == '0));
    end

    // stage 2
    logic s2_vld_reg;
    pos_t s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_reg <= s2_next;
        end
    end

    // stage 2 logic: integer texel, fraction and magnitude for the remainder
    logic [MOD_W-1:0] mod_x;
    logic [MOD_W-1:0] mod_y;
    div_t             div_in;

    assign mod_x = (wrap_s_reg == WRAP_MIRROR) ? {tex_width_reg, 1'b0}
                                               : {1'b0, tex_width_reg};
    assign mod_y = (wrap_t_reg == WRAP_MIRROR) ? {tex_height_reg, 1'b0}
                                               : {1'b0, tex_height_reg};

    always_comb begin
        div_in.zero   = s2_reg.zero;
        div_in.atlas  = s2_reg.atlas;
        div_in.is_wr  = s2_reg.is_wr;
        div_in.slot   = s2_reg.slot;
        div_in.wr_val = s2_reg.wr_val;
        div_in.x0     = s2_reg.fx[POS_W-1:FRAC_W];
        div_in.y0     = s2_reg.fy[POS_W-1:FRAC_W];
        div_in.tx     = s2_reg.fx[FRAC_W-1:0];
        div_in.ty     = s2_reg.fy[FRAC_W-1:0];
        div_in.minx   = s2_reg.minx;
        div_in.maxx   = s2_reg.maxx;
        div_in.miny   = s2_reg.miny;
        div_in.maxy   = s2_reg.maxy;
        div_in.xnum   = s2_reg.fx[POS_W-1] ? X_W'(-s2_reg.fx[POS_W-1:FRAC_W])
                                           : s2_reg.fx[POS_W-1:FRAC_W];
        div_in.ynum   = s2_reg.fy[POS_W-1] ? X_W'(-s2_reg.fy[POS_W-1:FRAC_W])
                                           : s2_reg.fy[POS_W-1:FRAC_W];
        div_in.xrem   = '0;
        div_in.yrem   = '0;
    end

    // remainder pipeline
    logic div_vld_reg [DIV_STAGES+1];
    div_t div_reg     [DIV_STAGES+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_vld_reg[0] <= 1'b0;
        end else if (en) begin
            div_vld_reg[0] <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg[0] <= div_in;
        end
    end

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
        div_t div_next;

        always_comb begin
            div_next      = div_reg[i];
            div_next.xrem = rem_step(div_reg[i].xrem, div_reg[i].xnum[X_W-1 -: DIV_BITS], mod_x);
            div_next.yrem = rem_step(div_reg[i].yrem, div_reg[i].ynum[X_W-1 -: DIV_BITS], mod_y);
            div_next.xnum = div_reg[i].xnum << DIV_BITS;
            div_next.ynum = div_reg[i].ynum << DIV_BITS;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                div_vld_reg[i+1] <= div_vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_reg[i+1] <= div_next;
            end
        end
    end

    // wrap stage logic: residues of both taps, then the wrap or clamp per axis
    div_t             dv;
    logic [MOD_W-1:0] rx0;
    logic [MOD_W-1:0] rx1;
    logic [MOD_W-1:0] ry0;
    logic [MOD_W-1:0] ry1;
    crd_t             crd_next;

    assign dv = div_reg[DIV_STAGES];

    always_comb begin
        rx0 = (dv.x0[X_W-1] && dv.xrem != '0) ? mod_x - dv.xrem : dv.xrem;
        ry0 = (dv.y0[X_W-1] && dv.yrem != '0) ? mod_y - dv.yrem : dv.yrem;
        rx1 = (rx0 + MOD_W'(1) == mod_x) ? '0 : rx0 + MOD_W'(1);
        ry1 = (ry0 + MOD_W'(1) == mod_y) ? '0 : ry0 + MOD_W'(1);

        crd_next.zero   = dv.zero;
        crd_next.is_wr  = dv.is_wr;
        crd_next.slot   = dv.slot;
        crd_next.wr_val = dv.wr_val;
        crd_next.tx     = dv.tx;
        crd_next.ty     = dv.ty;
        crd_next.xx0 = map_axis(dv.x0, rx0, tex_width_reg, mod_x, wrap_s_reg,
                                dv.atlas, dv.minx, dv.maxx);
        crd_next.xx1 = map_axis(dv.x0 + X_W'(1), rx1, tex_width_reg, mod_x, wrap_s_reg,
                                dv.atlas, dv.minx, dv.maxx);
        crd_next.yy0 = map_axis(dv.y0, ry0, tex_height_reg, mod_y, wrap_t_reg,
                                dv.atlas, dv.miny, dv.maxy);
        crd_next.yy1 = map_axis(dv.y0 + X_W'(1), ry1, tex_height_reg, mod_y, wrap_t_reg,
                                dv.atlas, dv.miny, dv.maxy);
    end

    logic crd_vld_reg;
    crd_t crd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crd_vld_reg <= 1'b0;
        end else if (en) begin
            crd_vld_reg <= div_vld_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            crd_reg <= crd_next;
        end
    end

    // address stage logic: row * width + column, wrapped to the store depth
    logic [SUM_W-1:0] row0;
    logic [SUM_W-1:0] row1;
    adr_t             adr_next;

    always_comb begin
        row0 = SUM_W'(crd_reg.yy0) * SUM_W'(tex_width_reg);
        row1 = SUM_W'(crd_reg.yy1) * SUM_W'(tex_width_reg);
        adr_next.zero   = crd_reg.zero;
        adr_next.is_wr  = crd_reg.is_wr;
        adr_next.wr_val = crd_reg.wr_val;
        adr_next.tx     = crd_reg.tx;
        adr_next.ty     = crd_reg.ty;
        adr_next.addr[1] = AW'(row0 + SUM_W'(crd_reg.xx1));
        adr_next.addr[2] = AW'(row1 + SUM_W'(crd_reg.xx0));
        adr_next.addr[3] = AW'(row1 + SUM_W'(crd_reg.xx1));
        // a texel write uses tap 0 as its write address
        if (crd_reg.is_wr) begin
            adr_next.addr[0] = AW'(SUM_W'(crd_reg.slot));
        end else begin
            adr_next.addr[0] = AW'(row0 + SUM_W'(crd_reg.xx0));
        end
    end

    logic adr_vld_reg;
    adr_t adr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adr_vld_reg <= 1'b0;
        end else if (en) begin
            adr_vld_reg <= crd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            adr_reg <= adr_next;
        end
    end

    // texel banks: one copy per tap
    logic [7:0] tap_rd_reg [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0] tex_mem [TEXEL_DEPTH];

        always_ff @(posedge aclk) begin
            if (en && adr_vld_reg && adr_reg.is_wr) begin
                tex_mem[adr_reg.addr[0]] <= adr_reg.wr_val;
            end
            if (en) begin
                tap_rd_reg[b] <= tex_mem[adr_reg.addr[b]];
            end
        end
    end

    logic              mem_vld_reg;
    logic              mem_zero_reg;
    logic [FRAC_W-1:0] mem_tx_reg;
    logic [FRAC_W-1:0] mem_ty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_vld_reg <= 1'b0;
        end else if (en) begin
            mem_vld_reg <= adr_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mem_zero_reg <= adr_reg.zero;
            mem_tx_reg   <= adr_reg.tx;
            mem_ty_reg   <= adr_reg.ty;
        end
    end

    // horizontal blend
    logic signed [8:0]  d_top;
    logic signed [8:0]  d_bot;
    logic signed [25:0] ha_next;
    logic signed [25:0] hb_next;

    always_comb begin
        d_top   = $signed({1'b0, tap_rd_reg[1]}) - $signed({1'b0, tap_rd_reg[0]});
        d_bot   = $signed({1'b0, tap_rd_reg[3]}) - $signed({1'b0, tap_rd_reg[2]});
        ha_next = $signed({1'b0, tap_rd_reg[0], 16'd0}) + d_top * $signed({1'b0, mem_tx_reg});
        hb_next = $signed({1'b0, tap_rd_reg[2], 16'd0}) + d_bot * $signed({1'b0, mem_tx_reg});
    end

    logic               hb_vld_reg;
    logic               hb_zero_reg;
    logic [FRAC_W-1:0]  hb_ty_reg;
    logic signed [25:0] ha_reg;
    logic signed [25:0] hb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hb_vld_reg <= 1'b0;
        end else if (en) begin
            hb_vld_reg <= mem_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hb_zero_reg <= mem_zero_reg;
            hb_ty_reg   <= mem_ty_reg;
            ha_reg      <= ha_next;
            hb_reg      <= hb_next;
        end
    end

    // vertical blend, Q8.32
    logic signed [43:0] vb_next;

    assign vb_next = ($signed(44'(ha_reg)) <<< 16)
                     + (44'(hb_reg) - 44'(ha_reg)) * $signed({1'b0, hb_ty_reg});

    logic               vb_vld_reg;
    logic               vb_zero_reg;
    logic signed [43:0] vb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_vld_reg <= 1'b0;
        end else if (en) begin
            vb_vld_reg <= hb_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vb_zero_reg <= hb_zero_reg;
            vb_reg      <= vb_next;
        end
    end

    // round half up to Q8.8 and saturate
    logic signed [43:0]     rnd;
    logic [M_TDATA_W-1:0]   out_next;

    always_comb begin
        rnd = (vb_reg + 44'sd8388608) >>> 24;
        if (vb_zero_reg || vb_reg < 0) begin
            out_next = '0;
        end else if (rnd > 44'(OUT_MAX)) begin
            out_next = M_TDATA_W'(OUT_MAX);
        end else begin
            out_next = rnd[M_TDATA_W-1:0];
        end
    end

    logic                 out_vld_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vb_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= out_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // remainder of a wrapped-path request stays below its modulus
    a_rem_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        div_vld_reg[DIV_STAGES] && !dv.zero && !dv.atlas
        |-> (dv.xrem < mod_x) && (dv.yrem < mod_y))
        else $error("remainder out of range");

    // writes and degenerate samples come out as zero
    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        vb_vld_reg && vb_zero_reg && en |=> m_tvalid && (m_tdata == '0))
        else $error("zero-flagged request gave nonzero result");

    // a stalled output freezes the pipeline
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vb_vld_reg) && $stable(crd_vld_reg) && $stable(s1_vld_reg))
        else $error("pipeline moved during stall");

    // result never exceeds full intensity
    a_out_max: assert property (@(posedge aclk) disable iff (!aresetn)
        vb_vld_reg && en |=> m_tdata <= M_TDATA_W'(OUT_MAX))
        else $error("result above full scale");
`endif

endmodule

>>> tb/tb_bilinear_texel_sampler_unit.sv
// testbench for bilinear_texel_sampler_unit: directed table, then random writes and samples
// checked against an in-bench bilinear predictor; depends on bts_pkg and the rtl
module tb_bilinear_texel_sampler_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import bts_pkg::*;

    localparam int DEPTH = TEXEL_DEPTH_DEF;
    localparam int SLOTS = FACE_SLOTS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        mode_t       mode;
        logic [15:0] slot;
        logic [7:0]  texel;
        logic [11:0] left;
        logic [11:0] top;
        logic [12:0] cols;
        logic [12:0] rows;
        logic [31:0] u;
        logic [31:0] v;
        logic [31:0] face;
    } req_t;

    typedef struct {
        req_t        r;
        bit          fixed;
        logic [15:0] want;
    } row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;

    bilinear_texel_sampler_unit dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor state
    logic [7:0]  texels [DEPTH];
    logic [11:0] rl [SLOTS];
    logic [11:0] rt [SLOTS];
    logic [12:0] rc [SLOTS];
    logic [12:0] rr [SLOTS];
    logic [12:0] p_w, p_h;
    wrap_mode_t  p_ws, p_wt;
    logic        p_atlas;
    logic [8:0]  p_faces;

    logic [15:0] expected_red [$];
    int errors = 0;
    int checked = 0;
    int samples = 0;
    int idle_cycles = 0;
    bit quiet_mode = 0;
    bit hold_off = 0;

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        errors++;
        if (errors <= 20)
            $display("mismatch %s at %0t: got %0d want %0d", what, $realtime, got, want);
    endtask

    function automatic longint wrap_coord(longint x, longint n, wrap_mode_t wm);
        longint r;
        if (n <= 1) return 0;
        if (wm == WRAP_REPEAT) begin
            r = x % n;
            return r < 0 ? r + n : r;
        end
        if (wm == WRAP_MIRROR) begin
            r = x % (2 * n);
            if (r < 0) r += 2 * n;
            return r < n ? r : 2 * n - 1 - r;
        end
        return x < 0 ? 0 : (x >= n ? n - 1 : x);
    endfunction

    function automatic longint clampr(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint floor_q16(longint p);
        if (p >= 0) return p / 65536;
        return -((-p + 65535) / 65536);
    endfunction

    function automatic logic [15:0] bilinear_red(req_t q);
        longint w, h, u, v, fx, fy, x0, y0, tx, ty, a, b, r, xs, ys, xx, yy;
        longint minx, miny, maxx, maxy;
        longint c [4];
        longint eff;
        bit atl;
        int fi;
        w = p_w; h = p_h;
        u = longint'($signed(q.u)); v = longint'($signed(q.v));
        eff = p_faces < SLOTS ? p_faces : SLOTS;
        atl = p_atlas && longint'(q.face) < eff;
        minx = 0; miny = 0; maxx = 0; maxy = 0;
        if (w == 0 || h == 0) return '0;
        if (atl) begin
            fi = q.face;
            if (rc[fi] == 0 || rr[fi] == 0) return '0;
            minx = rl[fi]; miny = rt[fi];
            maxx = minx + rc[fi] - 1; maxy = miny + rr[fi] - 1;
            fx = minx * 65536 + clampr(u, 0, 65536) * (maxx - minx);
            fy = miny * 65536 + (65536 - clampr(v, 0, 65536)) * (maxy - miny);
        end else begin
            fx = u * w - 32768;
            fy = v * h - 32768;
        end
        x0 = floor_q16(fx); y0 = floor_q16(fy);
        tx = fx - x0 * 65536; ty = fy - y0 * 65536;
        for (int k = 0; k < 4; k++) begin
            xs = x0 + (k & 1); ys = y0 + (k >> 1);
            if (atl) begin
                xx = clampr(xs, minx, maxx); yy = clampr(ys, miny, maxy);
            end else begin
                xx = wrap_coord(xs, w, p_ws); yy = wrap_coord(ys, h, p_wt);
            end
            c[k] = texels[(yy * w + xx) % DEPTH];
        end
        a = c[0] * 65536 + (c[1] - c[0]) * tx;
        b = c[2] * 65536 + (c[3] - c[2]) * tx;
        r = a * 65536 + (b - a) * ty;
        r = (r + (longint'(1) << 23)) / (longint'(1) << 24);
        if (r < 0) r = 0;
        if (r > 65280) r = 65280;
        return r[15:0];
    endfunction

    function automatic logic [15:0] apply_request(req_t q);
        case (q.mode)
            MODE_WR_TEXEL: begin
                texels[q.slot] = q.texel;
            end
            MODE_WR_RECT: begin
                if (q.slot < SLOTS) begin
                    rl[q.slot] = q.left; rt[q.slot] = q.top;
                    rc[q.slot] = q.cols; rr[q.slot] = q.rows;
                end
            end
            MODE_SAMPLE: return bilinear_red(q);
            default: ;
        endcase
        return '0;
    endfunction

    // output side: random stall, one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else if (hold_off) begin
            m_tready <= 0;
        end else begin
            m_tready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 15);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_red.size() == 0) begin
                report("unexpected result", m_tdata, 16'd0);
            end else begin
                logic [15:0] want;
                want = expected_red.pop_front();
                if (m_tdata !== want) report("red_value", m_tdata, want);
                checked++;
            end
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("TEST FAILED");
            $finish;
        end
    end

    // tvalid stays high after a request so the next one can follow at once
    task automatic send(input req_t q, input bit fixed, input logic [15:0] want);
        logic [15:0] pred;
        while (!quiet_mode && $urandom_range(99) < 15) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= q.mode;
        s_tdata <= {6'b0, q.face, q.v, q.u, q.rows, q.cols, q.top, q.left, q.texel, q.slot};
        do @(posedge aclk); while (!s_tready);
        pred = apply_request(q);
        if (fixed && pred !== want) report("table row", pred, want);
        if (q.mode == MODE_SAMPLE) samples++;
        expected_red.push_back(pred);
    endtask

    task automatic drain;
        s_tvalid <= 0;
        while (expected_red.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [12:0] val);
        cfg_wr_en <= 1; cfg_addr <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            CFG_TEX_WIDTH:  p_w = val;
            CFG_TEX_HEIGHT: p_h = val;
            CFG_WRAP_S:     p_ws = wrap_mode_t'(val[1:0]);
            CFG_WRAP_T:     p_wt = wrap_mode_t'(val[1:0]);
            CFG_ATLAS_MODE: p_atlas = val[0];
            CFG_FACE_COUNT: p_faces = val[8:0];
            default: ;
        endcase
    endtask

    task automatic setup(input int w, input int h, input int ws, input int wt,
                         input int atl, input int fc);
        drain();
        write_reg(CFG_TEX_WIDTH, 13'(w));
        write_reg(CFG_TEX_HEIGHT, 13'(h));
        write_reg(CFG_WRAP_S, 13'(ws));
        write_reg(CFG_WRAP_T, 13'(wt));
        write_reg(CFG_ATLAS_MODE, 13'(atl));
        write_reg(CFG_FACE_COUNT, 13'(fc));
    endtask

    function automatic req_t mk(mode_t m, int slot, int tv, int l, int t, int c, int r,
                                logic [31:0] u, logic [31:0] v, logic [31:0] f);
        req_t q;
        q.mode = m; q.slot = 16'(slot); q.texel = 8'(tv); q.left = 12'(l); q.top = 12'(t);
        q.cols = 13'(c); q.rows = 13'(r); q.u = u; q.v = v; q.face = f;
        return q;
    endfunction

    // fills all texels a sample can reach for the current size
    task automatic fill_texture(input int count);
        for (int i = 0; i < count; i++)
            send(mk(MODE_WR_TEXEL, i, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom), 0, 0);
    endtask

    // a random face id is either near the face count or above the table
    function automatic req_t random_sample(input int nface);
        logic [31:0] u, v;
        case ($urandom_range(3))
            0: u = $urandom;
            1: u = $urandom_range(131072) - 32768;
            default: u = $urandom_range(65536);
        endcase
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(131072) - 32768;
            default: v = $urandom_range(65536);
        endcase
        return mk(MODE_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  u, v, $urandom_range(1) ? $urandom_range(nface + 2)
                                          : ($urandom | 32'h0000_0100));
    endfunction

    row_t table_rows [$];

    initial begin
        int n;
        p_w = 0; p_h = 0; p_ws = WRAP_CLAMP_EDGE; p_wt = WRAP_CLAMP_EDGE;
        p_atlas = 0; p_faces = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed table: zero size after reset, writes, unused mode, extremes
        table_rows.push_back('{mk(MODE_SAMPLE, 0, 0, 0, 0, 0, 0, 32'h0000_8000,
                                 32'h0000_8000, 0), 1, 16'd0});
        table_rows.push_back('{mk(MODE_WR_TEXEL, 16'hFFFF, 8'hFF, 0, 0, 0, 0, 0, 0, 0),
                               1, 16'd0});
        table_rows.push_back('{mk(MODE_WR_RECT, 16'hFFFF, 0, 12'hFFF, 12'hFFF, 4096, 4096,
                                 0, 0, 0), 1, 16'd0});
        table_rows.push_back('{mk(MODE_NONE, 16'hFFFF, 8'hFF, 12'hFFF, 12'hFFF, 13'h1FFF,
                                 13'h1FFF, '1, '1, '1), 1, 16'd0});
        foreach (table_rows[i]) send(table_rows[i].r, table_rows[i].fixed, table_rows[i].want);

        // 4x4 texture, every wrap mode, coordinates at the extremes
        setup(4, 4, WRAP_REPEAT, WRAP_MIRROR, 0, 0);
        fill_texture(16);
        for (int m = 0; m < 4; m++) begin
            setup(4, 4, m, 3 - m, 0, 0);
            send(mk(MODE_SAMPLE, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0), 0, 0);
            send(mk(MODE_SAMPLE, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, '1), 0, 0);
            send(mk(MODE_SAMPLE, 0, 0, 0, 0, 0, 0, 32'h0000_2000, 32'hFFFF_E000, 0), 0, 0);
        end
        // axis of size one
        setup(1, 4, WRAP_REPEAT, WRAP_REPEAT, 0, 0);
        send(mk(MODE_SAMPLE, 0, 0, 0, 0, 0, 0, 32'h0001_4000, 32'h0000_6000, 0), 0, 0);
        // atlas: a face, an empty face, face beyond the count
        setup(4, 4, WRAP_CLAMP_EDGE, WRAP_CLAMP_EDGE, 1, 2);
        send(mk(MODE_WR_RECT, 0, 0, 1, 1, 2, 3, 0, 0, 0), 0, 0);
        send(mk(MODE_WR_RECT, 1, 0, 0, 0, 0, 2, 0, 0, 0), 0, 0);
        send(mk(MODE_SAMPLE, 0, 0, 0, 0, 0, 0, 32'h0000_8000, 32'hFFFF_0000, 0), 0, 0);
        send(mk(MODE_SAMPLE, 0, 0, 0, 0, 0, 0, 32'h0000_8000, 32'h0000_8000, 1), 1, 16'd0);
        send(mk(MODE_SAMPLE, 0, 0, 0, 0, 0, 0, 32'h0000_8000, 32'h0000_8000, 2), 0, 0);

        // random phases: sizes kept so every reachable texel is written first
        for (int ph = 0; ph < 8; ph++) begin
            int w, h, nf, atl;
            w = (ph == 7) ? 4096 : $urandom_range(1, 12);
            h = (ph == 7) ? 16 : $urandom_range(1, 12);
            if (ph == 6) begin w = 256; h = 256; end
            atl = ph % 2;
            nf = $urandom_range(1, 8);
            setup(w, h, (ph >= 6) ? 0 : $urandom_range(3), (ph >= 6) ? 0 : $urandom_range(3),
                  atl, ph == 5 ? 9'h1FF : nf);
            quiet_mode = (ph == 3);
            n = (w * h > DEPTH) ? DEPTH : w * h;
            if (ph < 6) begin
                fill_texture(n);
            end else begin
                // large texture: only the 4x4 corner that clamped samples reach
                for (int ry = 0; ry < 4; ry++)
                    for (int rx = 0; rx < 4; rx++)
                        send(mk(MODE_WR_TEXEL, ry * w + rx, $urandom, 0, 0, 0, 0, 0, 0, 0),
                             0, 0);
            end
            for (int f = 0; f < SLOTS && f < (ph == 5 ? nf + 3 : nf); f++) begin
                int l, t, c, r;
                c = $urandom_range(0, 6) == 0 ? 0 : $urandom_range(1, w);
                r = $urandom_range(1, h);
                l = $urandom_range(0, w - (c == 0 ? 1 : c));
                t = $urandom_range(0, h - r);
                send(mk(MODE_WR_RECT, f, $urandom, l, t, c, r, $urandom, $urandom, $urandom),
                     0, 0);
            end
            if (ph == 2) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge aclk);
                        hold_off = 0;
                    end
                join_none
            end
            if (ph >= 6) begin
                // large texture, sparse: only samples that reach written texels
                for (int i = 0; i < 40; i++) begin
                    req_t q;
                    q = random_sample(nf);
                    q.u = $urandom_range(3 * 65536 / w); q.v = $urandom_range(3 * 65536 / h);
                    q.face = '1;
                    send(q, 0, 0);
                end
            end else begin
                for (int i = 0; i < 40; i++) begin
                    if ($urandom_range(9) == 0)
                        send(mk(MODE_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom), 0, 0);
                    else if ($urandom_range(9) == 0)
                        send(mk(MODE_WR_TEXEL, $urandom_range(n - 1), $urandom, 0, 0, 0, 0,
                                0, 0, 0), 0, 0);
                    else
                        send(random_sample(nf), 0, 0);
                end
            end
            quiet_mode = 0;
        end

        drain();
        $display("covered %0d results, %0d of them samples, over wrap and atlas phases",
                 checked, samples);
        if (errors == 0 && expected_red.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/bts_pkg.sv
hw/rtl/bilinear_texel_sampler_unit.sv
tb/tb_bilinear_texel_sampler_unit.sv
